// File: sv/bwd_pkg.sv
// Shared types and constants of the burst window detector.
package bwd_pkg;

  localparam int TIME_W = 32;
  localparam int CNT_W  = 16;
  localparam int WIN_W  = 22;
  localparam int CFG_W  = 16;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] POS_MAX = 16'hFFFF;

  localparam logic [CFG_W-1:0] WINDOW_MINUTES_RST = 16'd10;
  localparam logic [CFG_W-1:0] HIT_THRESHOLD_RST  = 16'd5;

  // Register index, taken from address bit 2 (registers sit at 4*i).
  typedef enum logic {
    REG_WINDOW_MINUTES = 1'b0,
    REG_HIT_THRESHOLD  = 1'b1
  } reg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear;
    logic emit_gap;
    logic emit_last;
    logic push;
    logic pop;
    logic best;
    logic end_group;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gap;
    logic emit_ok;
    logic pop_ok;
    logic out_free;
    logic last;
  } sts_t;

endpackage

// File: sv/burst_window_detector.sv
// Top level of the burst window detector: configuration registers, controller and datapath.
//
// The input channel takes one event word per accepted handshake: a timestamp in
// seconds and a flag on the last event of a subject's group. Each activity
// segment (closed by a step larger than window_minutes * 60 seconds, or by the
// group's last event) yields at most one result word: the segment's largest
// sliding window, if its count reaches hit_threshold. One event can close two
// segments and so give two words; run_end marks the last word of an event.
// The input stalls until an event is done: it passes the gap, push, wait and check
// states; every entry that leaves the head of the window adds a wait and a check,
// and a group end adds the final state. Each head comparison waits for the ring
// memory's registered read port; every entry leaves the head at most once.
// A gap's word is registered from the gap state and a group end's word from the
// final state, unless an earlier word waits. The output register holds a word
// while the receiver stalls; the block goes on with the next event and only waits
// when a second word is due before the first was taken. Synchronous reset clears
// all control state and loads the register defaults (10 minutes, threshold 5);
// the ring needs no clearing. Registers sit at byte addresses 0 (window_minutes)
// and 4 (hit_threshold) and must be written by the user only while the block is idle;
// the block itself does not enforce this, and pready is always high.
module burst_window_detector #(
  parameter int RING_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bwd_pkg::TIME_W-1:0]     in_event_time,
  input  logic                           in_group_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bwd_pkg::CNT_W-1:0]      out_window_count,
  output logic [bwd_pkg::TIME_W-1:0]     out_first_time,
  output logic [bwd_pkg::TIME_W-1:0]     out_final_time,
  output logic [bwd_pkg::CNT_W-1:0]      out_first_pos,
  output logic [bwd_pkg::CNT_W-1:0]      out_final_pos,
  output logic                           out_ring_overflow,
  output logic                           out_run_end,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bwd_pkg::ADDR_W-1:0]     paddr,
  input  logic [bwd_pkg::DATA_W-1:0]     pwdata,
  output logic [bwd_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  logic [bwd_pkg::CFG_W-1:0] window_minutes_r, window_minutes_nxt;
  logic [bwd_pkg::CFG_W-1:0] hit_threshold_r, hit_threshold_nxt;
  logic                      cfg_write;
  bwd_pkg::reg_idx_t         cfg_idx;
  bwd_pkg::cmd_t             cmd;
  bwd_pkg::sts_t             sts;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // Register i sits at byte address 4*i; address bit 2 picks the register.
  assign cfg_idx   = bwd_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    window_minutes_nxt = window_minutes_r;
    hit_threshold_nxt  = hit_threshold_r;
    if (cfg_write) begin
      case (cfg_idx)
        bwd_pkg::REG_WINDOW_MINUTES: window_minutes_nxt = pwdata[bwd_pkg::CFG_W-1:0];
        bwd_pkg::REG_HIT_THRESHOLD:  hit_threshold_nxt  = pwdata[bwd_pkg::CFG_W-1:0];
        default: begin
          window_minutes_nxt = window_minutes_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bwd_pkg::REG_WINDOW_MINUTES: prdata = bwd_pkg::DATA_W'(window_minutes_r);
      bwd_pkg::REG_HIT_THRESHOLD:  prdata = bwd_pkg::DATA_W'(hit_threshold_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_minutes_r <= bwd_pkg::WINDOW_MINUTES_RST;
      hit_threshold_r  <= bwd_pkg::HIT_THRESHOLD_RST;
    end else begin
      window_minutes_r <= window_minutes_nxt;
      hit_threshold_r  <= hit_threshold_nxt;
    end
  end

  // The controller sequences gap check, push, head pops and segment closes.
  bwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the ring memory, the segment state and the output word.
  bwd_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_event_time     (in_event_time),
    .in_group_last     (in_group_last),
    .window_minutes    (window_minutes_r),
    .hit_threshold     (hit_threshold_r),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_count  (out_window_count),
    .out_first_time    (out_first_time),
    .out_final_time    (out_final_time),
    .out_first_pos     (out_first_pos),
    .out_final_pos     (out_final_pos),
    .out_ring_overflow (out_ring_overflow),
    .out_run_end       (out_run_end)
  );

endmodule

// File: sv/bwd_ctrl.sv
// Sequencing state machine of the burst window detector.
module bwd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bwd_pkg::sts_t sts,
  output bwd_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_PUSH,
    S_WAIT,
    S_CHECK,
    S_FINAL
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_GAP;
        end
      end
      S_GAP: begin
        if (sts.gap) begin
          if (sts.emit_ok) begin
            if (sts.out_free) begin
              cmd.emit_gap = 1'b1;
              cmd.clear    = 1'b1;
              state_nxt    = S_PUSH;
            end
          end else begin
            cmd.clear = 1'b1;
            state_nxt = S_PUSH;
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.pop_ok) begin
          cmd.pop   = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          cmd.best  = 1'b1;
          state_nxt = sts.last ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (sts.emit_ok) begin
          if (sts.out_free) begin
            cmd.emit_last = 1'b1;
            cmd.clear     = 1'b1;
            cmd.end_group = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.clear     = 1'b1;
          cmd.end_group = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/bwd_datapath.sv
// Datapath of the burst window detector: timestamp ring, segment state, output register.
module bwd_datapath #(
  parameter int RING_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [bwd_pkg::TIME_W-1:0]     in_event_time,
  input  logic                           in_group_last,
  input  logic [bwd_pkg::CFG_W-1:0]      window_minutes,
  input  logic [bwd_pkg::CFG_W-1:0]      hit_threshold,
  input  bwd_pkg::cmd_t                  cmd,
  output bwd_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bwd_pkg::CNT_W-1:0]      out_window_count,
  output logic [bwd_pkg::TIME_W-1:0]     out_first_time,
  output logic [bwd_pkg::TIME_W-1:0]     out_final_time,
  output logic [bwd_pkg::CNT_W-1:0]      out_first_pos,
  output logic [bwd_pkg::CNT_W-1:0]      out_final_pos,
  output logic                           out_ring_overflow,
  output logic                           out_run_end
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
  localparam logic [SW-1:0] FULL_SIZE = SW'(RING_DEPTH);

  function automatic logic [bwd_pkg::CNT_W-1:0] sat_inc(input logic [bwd_pkg::CNT_W-1:0] v);
    sat_inc = (v == bwd_pkg::POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    wrap_inc = (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  logic [bwd_pkg::TIME_W-1:0] ring_mem [RING_DEPTH];
  logic [bwd_pkg::TIME_W-1:0] rd_data_r;

  // Control state.
  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic [SW-1:0]              size_r, size_nxt;
  logic [bwd_pkg::CNT_W-1:0]  group_pos_r, group_pos_nxt;
  logic                       in_group_r, in_group_nxt;
  logic [bwd_pkg::CNT_W-1:0]  best_count_r, best_count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Payload state.
  logic [bwd_pkg::TIME_W-1:0] t_r, t_nxt;
  logic                       last_r, last_nxt;
  logic [bwd_pkg::TIME_W-1:0] prev_r, prev_nxt;
  logic [bwd_pkg::CNT_W-1:0]  pos_r, pos_nxt;
  logic [bwd_pkg::CNT_W-1:0]  head_pos_r, head_pos_nxt;
  logic [bwd_pkg::TIME_W-1:0] best_first_time_r, best_first_time_nxt;
  logic [bwd_pkg::TIME_W-1:0] best_final_time_r, best_final_time_nxt;
  logic [bwd_pkg::CNT_W-1:0]  best_first_pos_r, best_first_pos_nxt;
  logic [bwd_pkg::CNT_W-1:0]  best_final_pos_r, best_final_pos_nxt;
  logic [bwd_pkg::CNT_W-1:0]  o_count_r, o_count_nxt;
  logic [bwd_pkg::TIME_W-1:0] o_first_time_r, o_first_time_nxt;
  logic [bwd_pkg::TIME_W-1:0] o_final_time_r, o_final_time_nxt;
  logic [bwd_pkg::CNT_W-1:0]  o_first_pos_r, o_first_pos_nxt;
  logic [bwd_pkg::CNT_W-1:0]  o_final_pos_r, o_final_pos_nxt;
  logic                       o_ovf_r, o_ovf_nxt;
  logic                       o_run_end_r, o_run_end_nxt;

  logic [bwd_pkg::WIN_W-1:0]  win;
  logic [bwd_pkg::TIME_W-1:0] win_ext;
  logic                       ring_full;
  logic [31:0]                size_ext;
  logic [bwd_pkg::CNT_W-1:0]  count;
  logic                       emit;

  // Window in seconds: minutes * 64 - minutes * 4.
  assign win     = {window_minutes, 6'b0} - {4'b0, window_minutes, 2'b0};
  assign win_ext = bwd_pkg::TIME_W'(win);

  assign ring_full = (size_r == FULL_SIZE);
  assign size_ext  = 32'(size_r);
  assign count     = (size_ext > 32'(bwd_pkg::POS_MAX)) ? bwd_pkg::POS_MAX
                                                        : size_ext[bwd_pkg::CNT_W-1:0];
  assign emit      = cmd.emit_gap | cmd.emit_last;

  assign sts.gap      = in_group_r && (t_r > prev_r) && ((t_r - prev_r) > win_ext);
  assign sts.emit_ok  = (best_count_r != '0) && (best_count_r >= hit_threshold);
  assign sts.pop_ok   = (size_r > SW'(1)) && (t_r > rd_data_r) &&
                        ((t_r - rd_data_r) > win_ext);
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.last     = last_r;

  always_comb begin
    head_nxt            = head_r;
    tail_nxt            = tail_r;
    size_nxt            = size_r;
    group_pos_nxt       = group_pos_r;
    in_group_nxt        = in_group_r;
    best_count_nxt      = best_count_r;
    ovf_nxt             = ovf_r;
    t_nxt               = t_r;
    last_nxt            = last_r;
    prev_nxt            = prev_r;
    pos_nxt             = pos_r;
    head_pos_nxt        = head_pos_r;
    best_first_time_nxt = best_first_time_r;
    best_final_time_nxt = best_final_time_r;
    best_first_pos_nxt  = best_first_pos_r;
    best_final_pos_nxt  = best_final_pos_r;

    if (cmd.accept) begin
      t_nxt    = in_event_time;
      last_nxt = in_group_last;
    end

    if (cmd.clear) begin
      head_nxt       = '0;
      tail_nxt       = '0;
      size_nxt       = '0;
      best_count_nxt = '0;
      ovf_nxt        = 1'b0;
    end

    if (cmd.push) begin
      pos_nxt       = group_pos_r;
      group_pos_nxt = sat_inc(group_pos_r);
      tail_nxt      = wrap_inc(tail_r);
      if (size_r == '0) begin
        head_pos_nxt = group_pos_r;
      end
      if (ring_full) begin
        // The oldest entry is overwritten by the new one.
        head_nxt     = wrap_inc(head_r);
        head_pos_nxt = sat_inc(head_pos_r);
        ovf_nxt      = 1'b1;
      end else begin
        size_nxt = size_r + 1'b1;
      end
    end

    if (cmd.pop) begin
      head_nxt     = wrap_inc(head_r);
      size_nxt     = size_r - 1'b1;
      head_pos_nxt = sat_inc(head_pos_r);
    end

    if (cmd.best) begin
      if (count > best_count_r) begin
        best_count_nxt      = count;
        best_first_time_nxt = rd_data_r;
        best_final_time_nxt = t_r;
        best_first_pos_nxt  = head_pos_r;
        best_final_pos_nxt  = pos_r;
      end
      prev_nxt     = t_r;
      in_group_nxt = 1'b1;
    end

    if (cmd.end_group) begin
      in_group_nxt  = 1'b0;
      group_pos_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt    = out_valid_r;
    o_count_nxt      = o_count_r;
    o_first_time_nxt = o_first_time_r;
    o_final_time_nxt = o_final_time_r;
    o_first_pos_nxt  = o_first_pos_r;
    o_final_pos_nxt  = o_final_pos_r;
    o_ovf_nxt        = o_ovf_r;
    o_run_end_nxt    = o_run_end_r;
    if (emit) begin
      out_valid_nxt    = 1'b1;
      o_count_nxt      = best_count_r;
      o_first_time_nxt = best_first_time_r;
      o_final_time_nxt = best_final_time_r;
      o_first_pos_nxt  = best_first_pos_r;
      o_final_pos_nxt  = best_final_pos_r;
      o_ovf_nxt        = ovf_r;
      // After a gap the new segment holds one event, so the group end adds a
      // second word exactly when the threshold is at most one.
      o_run_end_nxt    = cmd.emit_last ||
                         !(last_r && (hit_threshold <= bwd_pkg::CFG_W'(1)));
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring_mem[tail_r] <= t_r;
    end
    rd_data_r <= ring_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      size_r       <= '0;
      group_pos_r  <= '0;
      in_group_r   <= 1'b0;
      best_count_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      size_r       <= size_nxt;
      group_pos_r  <= group_pos_nxt;
      in_group_r   <= in_group_nxt;
      best_count_r <= best_count_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r               <= t_nxt;
    last_r            <= last_nxt;
    prev_r            <= prev_nxt;
    pos_r             <= pos_nxt;
    head_pos_r        <= head_pos_nxt;
    best_first_time_r <= best_first_time_nxt;
    best_final_time_r <= best_final_time_nxt;
    best_first_pos_r  <= best_first_pos_nxt;
    best_final_pos_r  <= best_final_pos_nxt;
    o_count_r         <= o_count_nxt;
    o_first_time_r    <= o_first_time_nxt;
    o_final_time_r    <= o_final_time_nxt;
    o_first_pos_r     <= o_first_pos_nxt;
    o_final_pos_r     <= o_final_pos_nxt;
    o_ovf_r           <= o_ovf_nxt;
    o_run_end_r       <= o_run_end_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_window_count  = o_count_r;
  assign out_first_time    = o_first_time_r;
  assign out_final_time    = o_final_time_r;
  assign out_first_pos     = o_first_pos_r;
  assign out_final_pos     = o_final_pos_r;
  assign out_ring_overflow = o_ovf_r;
  assign out_run_end       = o_run_end_r;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the burst window detector.
module testbench;

  localparam int RING_DEPTH       = 256;
  // Settle time for the worst event, which drops every entry from the head of a full ring and ends its group.
  localparam int SETTLE_CYCLES    = 600;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES     = 1000000;
  localparam int RANDOM_PHASES    = 8;

  // Register settings of the random phases, the extremes among them.
  localparam logic [bwd_pkg::CFG_W-1:0] PHASE_WIN [RANDOM_PHASES] =
    '{16'd10, 16'd1, 16'd0, 16'd3, 16'd60, 16'd2, 16'd65535, 16'd20};
  localparam logic [bwd_pkg::CFG_W-1:0] PHASE_THR [RANDOM_PHASES] =
    '{16'd5, 16'd3, 16'd1, 16'd0, 16'd2, 16'd4, 16'd6, 16'd8};

  // One event word on the input channel.
  typedef struct {
    logic [bwd_pkg::TIME_W-1:0] stamp;
    logic                       is_last;
  } event_t;

  // One finding word on the result channel, in port order.
  typedef struct packed {
    logic [bwd_pkg::CNT_W-1:0]  window_count;
    logic [bwd_pkg::TIME_W-1:0] first_time;
    logic [bwd_pkg::TIME_W-1:0] final_time;
    logic [bwd_pkg::CNT_W-1:0]  first_pos;
    logic [bwd_pkg::CNT_W-1:0]  final_pos;
    logic                       ring_overflow;
    logic                       run_end;
  } finding_t;

  // All block inputs start at known values.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic [bwd_pkg::TIME_W-1:0]  in_event_time = '0;
  logic                        in_group_last = 1'b0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic [bwd_pkg::CNT_W-1:0]   out_window_count;
  logic [bwd_pkg::TIME_W-1:0]  out_first_time;
  logic [bwd_pkg::TIME_W-1:0]  out_final_time;
  logic [bwd_pkg::CNT_W-1:0]   out_first_pos;
  logic [bwd_pkg::CNT_W-1:0]   out_final_pos;
  logic                        out_ring_overflow;
  logic                        out_run_end;
  logic                        psel          = 1'b0;
  logic                        penable       = 1'b0;
  logic                        pwrite        = 1'b0;
  logic [bwd_pkg::ADDR_W-1:0]  paddr         = '0;
  logic [bwd_pkg::DATA_W-1:0]  pwdata        = '0;
  logic [bwd_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  burst_window_detector #(
    .RING_DEPTH(RING_DEPTH)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_event_time    (in_event_time),
    .in_group_last    (in_group_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_window_count (out_window_count),
    .out_first_time   (out_first_time),
    .out_final_time   (out_final_time),
    .out_first_pos    (out_first_pos),
    .out_final_pos    (out_final_pos),
    .out_ring_overflow(out_ring_overflow),
    .out_run_end      (out_run_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk = ~clk;

  // Event words waiting for the driver, and findings waiting for the monitor.
  event_t   event_queue[$];
  finding_t expected_findings[$];

  int issued_count   = 0;
  int accepted_count = 0;
  int failure_count  = 0;

  // Idling controls, set per phase by the stimulus process.
  bit sender_idle_on   = 1'b1;
  bit receiver_idle_on = 1'b1;
  bit long_hold_req    = 1'b0;

  // Register copies as the block should hold them.
  logic [bwd_pkg::CFG_W-1:0] window_minutes_q = bwd_pkg::WINDOW_MINUTES_RST;
  logic [bwd_pkg::CFG_W-1:0] hit_threshold_q  = bwd_pkg::HIT_THRESHOLD_RST;

  // Predictor state: the sliding window ring and the best window of the open segment.
  logic [bwd_pkg::TIME_W-1:0] ring_q [RING_DEPTH];
  int                         head_q;
  int                         size_q;
  logic [bwd_pkg::TIME_W-1:0] prev_time_q;
  logic [bwd_pkg::CNT_W-1:0]  group_pos_q;
  logic [bwd_pkg::CNT_W-1:0]  head_pos_q;
  bit                         in_group_q;
  int                         best_count_q;
  logic [bwd_pkg::TIME_W-1:0] best_first_time_q;
  logic [bwd_pkg::TIME_W-1:0] best_final_time_q;
  logic [bwd_pkg::CNT_W-1:0]  best_first_pos_q;
  logic [bwd_pkg::CNT_W-1:0]  best_final_pos_q;
  bit                         overflow_q;

  function automatic logic [bwd_pkg::CNT_W-1:0] sat_inc(logic [bwd_pkg::CNT_W-1:0] v);
    return (v == bwd_pkg::POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void clear_segment_state();
    head_q            = 0;
    size_q            = 0;
    best_count_q      = 0;
    best_first_time_q = '0;
    best_final_time_q = '0;
    best_first_pos_q  = '0;
    best_final_pos_q  = '0;
    overflow_q        = 1'b0;
    head_pos_q        = '0;
  endfunction

  // Closes the open segment; returns 1 if its best window makes a finding.
  function automatic int close_segment_finding();
    finding_t f;
    int       made;
    made = 0;
    if (best_count_q > 0 && best_count_q >= hit_threshold_q) begin
      f.window_count  = bwd_pkg::CNT_W'(best_count_q);
      f.first_time    = best_first_time_q;
      f.final_time    = best_final_time_q;
      f.first_pos     = best_first_pos_q;
      f.final_pos     = best_final_pos_q;
      f.ring_overflow = overflow_q;
      f.run_end       = 1'b0;
      expected_findings.insert(expected_findings.size(), f);
      made = 1;
    end
    clear_segment_state();
    return made;
  endfunction

  // Advances the predictor by one accepted event and queues the findings it causes.
  function automatic void predict_findings(logic [bwd_pkg::TIME_W-1:0] t, logic is_last);
    logic [bwd_pkg::TIME_W-1:0] win;
    logic [bwd_pkg::TIME_W-1:0] oldest;
    logic [bwd_pkg::CNT_W-1:0]  pos;
    finding_t                   tail;
    int                         made;
    bit                         dropping;
    win  = {16'd0, window_minutes_q} * 32'd60;
    made = 0;
    // A forward step beyond the window closes the segment; a backward step never does.
    if (in_group_q && t > prev_time_q && (t - prev_time_q) > win)
      made += close_segment_finding();
    pos         = group_pos_q;
    group_pos_q = sat_inc(group_pos_q);
    if (size_q == 0)
      head_pos_q = pos;
    // A full ring loses its oldest entry and marks the segment as overflowed.
    if (size_q >= RING_DEPTH) begin
      head_q     = (head_q + 1) % RING_DEPTH;
      size_q     = size_q - 1;
      head_pos_q = sat_inc(head_pos_q);
      overflow_q = 1'b1;
    end
    ring_q[(head_q + size_q) % RING_DEPTH] = t;
    size_q = size_q + 1;
    dropping = 1'b1;
    while (dropping && size_q > 1) begin
      oldest = ring_q[head_q];
      if (t > oldest && (t - oldest) > win) begin
        head_q     = (head_q + 1) % RING_DEPTH;
        size_q     = size_q - 1;
        head_pos_q = sat_inc(head_pos_q);
      end else begin
        dropping = 1'b0;
      end
    end
    // Strictly larger only, so ties keep the earliest window.
    if (size_q > best_count_q) begin
      best_count_q      = size_q;
      best_first_time_q = ring_q[head_q];
      best_final_time_q = t;
      best_first_pos_q  = head_pos_q;
      best_final_pos_q  = pos;
    end
    prev_time_q = t;
    in_group_q  = 1'b1;
    if (is_last) begin
      made += close_segment_finding();
      in_group_q  = 1'b0;
      group_pos_q = '0;
    end
    if (made > 0) begin
      tail         = expected_findings[expected_findings.size() - 1];
      tail.run_end = 1'b1;
      expected_findings[expected_findings.size() - 1] = tail;
    end
  endfunction

  // Driver: offers the queued event words, each after a random number of idle
  // cycles while sender idling is on. A word is taken at an edge with in_valid
  // high and in_stall low, and the predictor runs on it at that same edge.
  bit offering = 1'b0;
  int send_gap = 0;

  always @(posedge clk) begin
    event_t ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_findings(in_event_time, in_group_last);
        accepted_count++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (event_queue.size() != 0) begin
          ev = event_queue.pop_front();
          in_event_time <= ev.stamp;
          in_group_last <= ev.is_last;
          offering = 1'b1;
          send_gap = sender_idle_on ? $urandom_range(0, 12) : 0;
        end
      end
      // Assigned once per edge, so back-to-back words keep valid high.
      in_valid <= offering;
    end
  end

  function automatic string finding_text(finding_t f);
    return $sformatf("cnt=%0d t=%h..%h pos=%0d..%0d ovf=%b end=%b", f.window_count,
                     f.first_time, f.final_time, f.first_pos, f.final_pos,
                     f.ring_overflow, f.run_end);
  endfunction

  task automatic log_failure(string what, finding_t want, finding_t got);
    failure_count++;
    if (failure_count <= 10)
      $display("%s: expected %s, got %s", what, finding_text(want), finding_text(got));
  endtask

  // Monitor: checks each finding word against the oldest expectation and
  // drives out_stall. After each word the receiver stalls for a random number
  // of cycles while receiver idling is on; once per run it holds off for a long
  // stretch so that the block fills up and stalls its input.
  int stall_left = 0;
  int hold_left  = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    finding_t got;
    finding_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_window_count, out_first_time, out_final_time, out_first_pos,
               out_final_pos, out_ring_overflow, out_run_end};
        if (expected_findings.size() == 0) begin
          log_failure("unexpected finding", '0, got);
        end else begin
          want = expected_findings.pop_front();
          if (got.window_count !== want.window_count || got.first_time !== want.first_time ||
              got.final_time !== want.final_time || got.first_pos !== want.first_pos ||
              got.final_pos !== want.final_pos || got.ring_overflow !== want.ring_overflow ||
              got.run_end !== want.run_end)
            log_failure("finding mismatch", want, got);
        end
        stall_left = receiver_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_event(logic [bwd_pkg::TIME_W-1:0] stamp, logic is_last);
    event_t ev;
    ev.stamp   = stamp;
    ev.is_last = is_last;
    event_queue.insert(event_queue.size(), ev);
    issued_count++;
  endtask

  // Queues one subject's events. Steps are mostly inside the window, with
  // steps of exactly the window and one past it, gaps, backward steps and
  // random jumps mixed in. A dense group packs more events than the ring holds.
  task automatic queue_group(int len, bit dense, bit closed);
    logic [bwd_pkg::TIME_W-1:0] t;
    logic [bwd_pkg::TIME_W-1:0] win;
    int                         kind;
    win = {16'd0, window_minutes_q} * 32'd60;
    case ($urandom_range(0, 3))
      0:       t = $urandom_range(0, 1000);
      1:       t = 32'hFFFF_FFFF - $urandom_range(0, 3 * win + 10);
      default: t = $urandom;
    endcase
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        kind = $urandom_range(0, 99);
        if (dense)          t = t + $urandom_range(0, 1);
        else if (kind < 10) t = t;
        else if (kind < 62) t = t + $urandom_range(0, win / 4 + 1);
        else if (kind < 70) t = t + win;
        else if (kind < 76) t = t + win + 1;
        else if (kind < 88) t = t + $urandom_range(win + 1, 3 * win + 2);
        else if (kind < 95) t = t - $urandom_range(1, win + 5);
        else                t = $urandom;
      end
      queue_event(t, closed && i == len - 1);
    end
  endtask

  // Queues groups until about the given number of events is pending. A few
  // groups lack their end mark and so run into the next group.
  task automatic queue_random_phase(int budget);
    int start;
    int r;
    bit dense;
    int len;
    start = issued_count;
    while (issued_count - start < budget) begin
      r     = $urandom_range(0, 99);
      dense = (r < 3);
      len   = dense ? $urandom_range(257, 290) :
              (r < 15) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      queue_group(len, dense, $urandom_range(0, 19) != 0);
    end
  endtask

  // Waits until every queued word is taken and every finding has come, then
  // lets the block finish any event that makes no finding.
  task automatic wait_until_idle();
    while (accepted_count != issued_count || expected_findings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write with a setup and an access phase; the register takes the data at the access edge.
  task automatic write_reg(bwd_pkg::reg_idx_t idx, logic [bwd_pkg::CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bwd_pkg::REG_WINDOW_MINUTES)
      window_minutes_q = value;
    else
      hit_threshold_q = value;
  endtask

  task automatic configure(logic [bwd_pkg::CFG_W-1:0] minutes,
                           logic [bwd_pkg::CFG_W-1:0] threshold);
    write_reg(bwd_pkg::REG_WINDOW_MINUTES, minutes);
    write_reg(bwd_pkg::REG_HIT_THRESHOLD, threshold);
  endtask

  // Stimulus: reset, a directed part, the ring-overflow and back-pressure
  // phases, and random phases over several register settings.
  initial begin
    logic [bwd_pkg::TIME_W-1:0] t;
    clear_segment_state();
    prev_time_q = '0;
    group_pos_q = '0;
    in_group_q  = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 600 second window, threshold 5. The first group ends
    // exactly one window after its start, so nothing is dropped.
    queue_event(32'd0, 1'b0);
    queue_event(32'd0, 1'b0);
    queue_event(32'd60, 1'b0);
    queue_event(32'd600, 1'b0);
    queue_event(32'd600, 1'b1);
    // A step one second past the window closes the first segment on the
    // group's final event; the lone event after it is under the threshold.
    queue_event(32'd1000, 1'b0);
    queue_event(32'd1001, 1'b0);
    queue_event(32'd1002, 1'b0);
    queue_event(32'd1003, 1'b0);
    queue_event(32'd1004, 1'b0);
    queue_event(32'd1605, 1'b1);
    // Time going backwards is never a gap, and a later head entry stays.
    queue_event(32'd5000, 1'b0);
    queue_event(32'd4000, 1'b0);
    queue_event(32'd4000, 1'b0);
    queue_event(32'd5000, 1'b0);
    queue_event(32'd5000, 1'b1);
    wait_until_idle();

    // Zero window and zero threshold: every closed segment is a finding, and
    // a gap on a group's final event gives two words, the gap's first.
    configure(16'd0, 16'd0);
    queue_event(32'hFFFF_FFFF, 1'b1);
    queue_event(32'd0, 1'b0);
    queue_event(32'd1, 1'b1);
    queue_event(32'hFFFF_FFFE, 1'b0);
    queue_event(32'hFFFF_FFFF, 1'b0);
    queue_event(32'd0, 1'b1);
    wait_until_idle();

    // Widest window: more events than the ring holds, once all at one time
    // and once one second apart.
    configure(16'd65535, 16'd200);
    t = $urandom;
    for (int i = 0; i < 270; i++)
      queue_event(t, i == 269);
    t = $urandom_range(0, 32'h8000_0000);
    for (int i = 0; i < 280; i++)
      queue_event(t + i, i == 279);
    wait_until_idle();

    // Back-pressure: every step between events closes a segment with a finding, the sender
    // never idles and the receiver holds off for a long stretch.
    configure(16'd0, 16'd0);
    sender_idle_on = 1'b0;
    long_hold_req  = 1'b1;
    t = $urandom_range(0, 32'h1000_0000);
    for (int i = 0; i < 80; i++)
      queue_event(t + 3 * i, i == 79);
    wait_until_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(PHASE_WIN[p], PHASE_THR[p]);
      sender_idle_on   = ($urandom_range(0, 3) != 0);
      receiver_idle_on = ($urandom_range(0, 3) != 0);
      queue_random_phase(130);
      wait_until_idle();
    end

    // A small random setting, then an unreachable threshold.
    configure(16'($urandom_range(0, 30)), 16'($urandom_range(0, 8)));
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    queue_random_phase(100);
    wait_until_idle();
    configure(16'd10, 16'd65535);
    queue_random_phase(40);
    wait_until_idle();

    if (failure_count == 0 && expected_findings.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
